// ----- hdl/kss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package kss_pkg;
	localparam int unsigned MAX_SLOTS = 4096;
	localparam int unsigned ADDR_W = 12;
	localparam int unsigned CNT_W = 13;

	localparam logic [63:0] SEED_INIT = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SEED_MUL = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SEED_ADD = 64'h94d049bb133111eb;
	localparam logic [63:0] SEED_ZERO_SUB = 64'h517cc1b727220a95;
	localparam logic [63:0] OUT_MUL = 64'h2545f4914f6cdd1d;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_COUNT = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;

	localparam logic [2:0] REG_SLOT_COUNT = 3'd0;
	localparam logic [2:0] REG_KEY_0 = 3'd1;
	localparam logic [2:0] REG_KEY_3 = 3'd4;

	localparam logic REQ_BUILD = 1'b0;

	typedef struct packed {
		logic start;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
	} mul_req_t;

	typedef struct packed {
		logic start;
		logic [63:0] num;
		logic [CNT_W-1:0] den;
	} mod_req_t;
endpackage
`default_nettype wire

// ----- hdl/kss_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kss_ram #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 4096
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/kss_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// low 64 bits of a*b + c, one 32x32 product per cycle
module kss_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire kss_pkg::mul_req_t req,
	output logic done,
	output logic [63:0] p
);
	logic [63:0] a_q, b_q, acc_q;
	logic [1:0] ph_q;
	logic busy_q;
	logic [31:0] op_x, op_y;
	logic [63:0] prod;

	assign op_x = (ph_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign op_y = (ph_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	assign prod = op_x * op_y;
	assign p = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				ph_q <= 2'd0;
			end else if (busy_q) begin
				if (ph_q == 2'd2) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= req.c;
		end else if (busy_q) begin
			if (ph_q == 2'd0) begin
				acc_q <= acc_q + prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'h0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/kss_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// num mod den, one quotient bit per cycle
module kss_mod (
	input wire logic clk,
	input wire logic arst_n,
	input wire kss_pkg::mod_req_t req,
	output logic done,
	output logic [kss_pkg::ADDR_W-1:0] rem
);
	logic [63:0] num_q;
	logic [kss_pkg::CNT_W-1:0] den_q, rem_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [kss_pkg::CNT_W:0] t, t_sub;

	assign t = {rem_q, num_q[63]};
	assign t_sub = (t >= {1'b0, den_q}) ? t - {1'b0, den_q} : t;
	assign rem = rem_q[kss_pkg::ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			rem_q <= t_sub[kss_pkg::CNT_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/keyed_slot_shuffle.sv -----
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req_type, read_index
// result  | rsp_valid | rsp_stall | status, entry_value
// Read: an in-range read passes S_RD and S_DONE; an out-of-range read goes to S_DONE.
// Build: fill writes each slot with its own index, then 32 seed rounds on the
// shared 32x32 multiplier, then n-1 shuffle steps, each paced by the serial
// remainder unit and the table reads through its single read port.
// Reset clears control state, built count, generator state and registers.
// req_stall is high while a request is in work; a finished word waits
// behind a result held by rsp_stall.
`timescale 1ns / 1ps
`default_nettype none
module keyed_slot_shuffle (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [2:0] wr_index,
	input wire logic [63:0] wr_data,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic req_type,
	input wire logic [11:0] read_index,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output logic [1:0] status,
	output logic [11:0] entry_value
);
	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_RD = 13'b0000000000010,
		S_FILL = 13'b0000000000100,
		S_FOLD = 13'b0000000001000,
		S_FOLD_W = 13'b0000000010000,
		S_GEN = 13'b0000000100000,
		S_OUT_W = 13'b0000001000000,
		S_MOD_W = 13'b0000010000000,
		S_SW0 = 13'b0000100000000,
		S_SW1 = 13'b0001000000000,
		S_SW2 = 13'b0010000000000,
		S_SW3 = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	localparam int unsigned AW = kss_pkg::ADDR_W;
	localparam int unsigned CW = kss_pkg::CNT_W;

	state_t state_q;
	logic [CW-1:0] slot_count_q, built_count_q, n_q, cnt_q;
	logic [63:0] key_q [4];
	logic [63:0] s_q, rng_q, xs;
	logic [4:0] b_q;
	logic [AW-1:0] i_q, j_q, ti_q;
	logic [1:0] res_status_q;
	logic [AW-1:0] res_value_q;
	logic rsp_valid_q;
	logic [1:0] status_q;
	logic [AW-1:0] entry_q;

	kss_pkg::mul_req_t mul_req;
	kss_pkg::mod_req_t mod_req;
	logic mul_done, mod_done;
	logic [63:0] mul_p;
	logic [AW-1:0] mod_rem;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;
	logic accept, out_free;
	logic [63:0] key_byte, x1, x2, seed;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign accept = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign entry_value = entry_q;

	assign key_byte = key_q[b_q[4:3]] & (64'hff << {b_q[2:0], 3'b000});
	assign x1 = rng_q ^ (rng_q >> 12);
	assign x2 = x1 ^ (x1 << 25);
	assign xs = x2 ^ (x2 >> 27);
	assign seed = (mul_p == 64'h0) ? kss_pkg::SEED_ZERO_SUB : mul_p;

	always_comb begin
		mul_req = '0;
		mod_req = '0;
		ram_we = 1'b0;
		ram_waddr = i_q;
		ram_wdata = ram_rdata;
		ram_raddr = read_index;
		case (state_q)
			S_FOLD: begin
				mul_req.start = 1'b1;
				mul_req.a = s_q ^ key_byte;
				mul_req.b = kss_pkg::SEED_MUL;
				mul_req.c = kss_pkg::SEED_ADD;
			end
			S_GEN: begin
				mul_req.start = 1'b1;
				mul_req.a = xs;
				mul_req.b = kss_pkg::OUT_MUL;
			end
			S_OUT_W: begin
				mod_req.start = mul_done;
				mod_req.num = mul_p;
				mod_req.den = {1'b0, i_q} + 1'b1;
			end
			S_FILL: begin
				ram_we = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = cnt_q[AW-1:0];
			end
			S_SW0: ram_raddr = i_q;
			S_SW1: ram_raddr = j_q;
			S_SW2: ram_we = 1'b1;
			S_SW3: begin
				ram_we = 1'b1;
				ram_waddr = j_q;
				ram_wdata = ti_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_count_q <= '0;
			for (int k = 0; k < 4; k++) begin
				key_q[k] <= '0;
			end
			built_count_q <= '0;
			rng_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				if (wr_index == kss_pkg::REG_SLOT_COUNT) begin
					slot_count_q <= wr_data[CW-1:0];
				end else if (wr_index >= kss_pkg::REG_KEY_0 &&
						wr_index <= kss_pkg::REG_KEY_3) begin
					key_q[2'(wr_index - kss_pkg::REG_KEY_0)] <= wr_data;
				end
			end
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == kss_pkg::REQ_BUILD) begin
							if (slot_count_q == '0 ||
									slot_count_q > CW'(kss_pkg::MAX_SLOTS)) begin
								built_count_q <= '0;
								state_q <= S_DONE;
							end else begin
								state_q <= S_FILL;
							end
						end else if ({1'b0, read_index} >= built_count_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_DONE;
				S_FILL: begin
					if (cnt_q == n_q - 1'b1) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: state_q <= S_FOLD_W;
				S_FOLD_W: begin
					if (mul_done) begin
						if (b_q == 5'd31) begin
							rng_q <= seed;
							if (n_q == CW'(1)) begin
								built_count_q <= n_q;
								state_q <= S_DONE;
							end else begin
								state_q <= S_GEN;
							end
						end else begin
							state_q <= S_FOLD;
						end
					end
				end
				S_GEN: begin
					rng_q <= xs;
					state_q <= S_OUT_W;
				end
				S_OUT_W: begin
					if (mul_done) begin
						state_q <= S_MOD_W;
					end
				end
				S_MOD_W: begin
					if (mod_done) begin
						state_q <= S_SW0;
					end
				end
				S_SW0: state_q <= S_SW1;
				S_SW1: state_q <= S_SW2;
				S_SW2: state_q <= S_SW3;
				S_SW3: begin
					if (i_q == AW'(1)) begin
						built_count_q <= n_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_GEN;
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q <= slot_count_q;
				cnt_q <= '0;
				res_value_q <= '0;
				if (req_type == kss_pkg::REQ_BUILD) begin
					res_status_q <= (slot_count_q == '0 ||
						slot_count_q > CW'(kss_pkg::MAX_SLOTS)) ?
						kss_pkg::ST_BAD_COUNT : kss_pkg::ST_OK;
				end else begin
					res_status_q <= ({1'b0, read_index} >= built_count_q) ?
						kss_pkg::ST_BAD_INDEX : kss_pkg::ST_OK;
				end
			end
			S_RD: res_value_q <= ram_rdata;
			S_FILL: begin
				cnt_q <= cnt_q + 1'b1;
				s_q <= kss_pkg::SEED_INIT;
				b_q <= '0;
				i_q <= AW'(n_q - 1'b1);
			end
			S_FOLD_W: begin
				if (mul_done) begin
					s_q <= mul_p;
					b_q <= b_q + 5'd1;
				end
			end
			S_MOD_W: begin
				if (mod_done) begin
					j_q <= mod_rem;
				end
			end
			S_SW1: ti_q <= ram_rdata;
			S_SW3: i_q <= i_q - 1'b1;
			S_DONE: begin
				if (out_free) begin
					status_q <= res_status_q;
					entry_q <= res_value_q;
				end
			end
			default: ;
		endcase
	end

	kss_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mul_req),
		.done(mul_done),
		.p(mul_p)
	);

	kss_mod u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.req(mod_req),
		.done(mod_done),
		.rem(mod_rem)
	);

	kss_ram #(
		.WIDTH(AW),
		.DEPTH(kss_pkg::MAX_SLOTS)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != kss_pkg::ST_OK |-> entry_q == '0)
		else $error("error result with nonzero entry");
	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SW0 |-> j_q <= i_q)
		else $error("swap partner above current slot");
	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == S_FOLD_W || state_q == S_OUT_W)
		else $error("multiplier finished outside a wait state");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> req_stall)
		else $error("request taken while busy");
endmodule
`default_nettype wire
